/* hw/rtl/lhr_pkg.sv */
// ----------------------------------------------------------------------------
// Line history ring package
// Types, sizes and codes shared by the record history modules.
// ----------------------------------------------------------------------------
package lhr_pkg;

  localparam int unsigned STORE_BYTES  = 8192;
  localparam int unsigned RING_ENTRIES = 128;

  localparam int unsigned LEN_W    = 14;
  localparam int unsigned STORE_AW = $clog2(STORE_BYTES);
  localparam int unsigned OFS_W    = STORE_AW + 1;
  localparam int unsigned RING_AW  = $clog2(RING_ENTRIES);
  localparam int unsigned CALC_W   = ((OFS_W > LEN_W) ? OFS_W : LEN_W) + 1;
  localparam int unsigned IDX_W    = ((RING_AW > 7) ? RING_AW : 7) + 1;

  localparam logic [CALC_W-1:0]   STORE_C    = CALC_W'(STORE_BYTES);
  localparam logic [CALC_W-1:0]   HALF_C     = CALC_W'(STORE_BYTES / 2);
  localparam logic [CALC_W-1:0]   OFS_MOD_C  = CALC_W'(2 * STORE_BYTES);
  localparam logic [STORE_AW-1:0] STORE_LAST = STORE_AW'(STORE_BYTES - 1);
  localparam logic [RING_AW-1:0]  RING_LAST  = RING_AW'(RING_ENTRIES - 1);
  localparam logic [RING_AW:0]    RING_N_C   = (RING_AW + 1)'(RING_ENTRIES);
  localparam logic [IDX_W-1:0]    RING_IDX_C = IDX_W'(RING_ENTRIES);

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_FETCH   = 2'd1,
    ACT_DISCARD = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    OFS_NEWEST = 2'd0,
    OFS_OLDEST = 2'd1,
    OFS_SLOT   = 2'd2,
    OFS_NEXT   = 2'd3
  } ofs_sel_e;

  typedef struct packed {
    logic [1:0]  action;
    logic        first;
    logic [13:0] line_length;
    logic [7:0]  data_byte;
    logic [6:0]  which;
    logic [12:0] offset;
    logic [13:0] max_length;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  entry_count;
    logic [7:0]  fetched_byte;
    logic [12:0] fetched_length;
  } result_t;

  typedef struct packed {
    logic     latch_item;
    logic     clear_pending;
    logic     oldest_inc;
    logic     ofs_re;
    ofs_sel_e ofs_sel;
    logic     cap_dest;
    logic     commit;
    logic     store_byte;
    logic     discard;
    logic     set_acc;
    logic     cap_slot_ofs;
    logic     cap_size;
    logic     byte_re;
    logic     cap_byte;
    logic     emit;
  } lhr_cmd_t;

  typedef struct packed {
    logic act_append;
    logic act_fetch;
    logic act_discard;
    logic first;
    logic len_ok;
    logic ring_full;
    logic pending;
    logic which_ok;
    logic have_record;
    logic fits;
    logic byte_in_range;
  } lhr_status_t;

endpackage

/* hw/rtl/lhr_ram.sv */
// ----------------------------------------------------------------------------
// Line history ring RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lhr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/lhr_dp.sv */
// ----------------------------------------------------------------------------
// Line history ring datapath
// Byte store, start offset ring, indices and result register.
// ----------------------------------------------------------------------------
module lhr_dp
  import lhr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  item_t       item_i,
  input  lhr_cmd_t    cmd_i,
  output lhr_status_t status_o,
  output logic        done_o,
  output result_t     result_o
);

  function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] x);
    return (x == RING_LAST) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [RING_AW-1:0] ring_dec(input logic [RING_AW-1:0] x);
    return (x == '0) ? RING_LAST : x - 1'b1;
  endfunction

  function automatic logic [STORE_AW-1:0] store_inc(input logic [STORE_AW-1:0] x);
    return (x == STORE_LAST) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [CALC_W-1:0] ofs_diff(input logic [CALC_W-1:0] a,
                                                 input logic [CALC_W-1:0] b);
    return (a >= b) ? a - b : a + OFS_MOD_C - b;
  endfunction

  function automatic logic [STORE_AW-1:0] store_wrap(input logic [CALC_W-1:0] x);
    return (x >= STORE_C) ? STORE_AW'(x - STORE_C) : STORE_AW'(x);
  endfunction

  item_t                   item_q;
  logic [RING_AW-1:0]      oldest_q, oldest_d;
  logic [RING_AW-1:0]      newest_q, newest_d;
  logic [STORE_AW-1:0]     wp_q, wp_d;
  logic [OFS_W-1:0]        rem_q, rem_d;
  logic [RING_ENTRIES-1:0] valid_q, valid_d;
  logic                    rd_vld_q;
  logic                    done_q;
  logic [OFS_W-1:0]        dest_q;
  logic [OFS_W-1:0]        slot_ofs_q;
  logic [LEN_W-1:0]        size_q;
  logic                    acc_q;
  logic [7:0]              fbyte_q;
  result_t                 result_q;

  logic [RING_AW:0]    count_wide;
  logic [RING_AW-1:0]  count;
  logic [IDX_W-1:0]    which_x;
  logic [IDX_W-1:0]    newest_x;
  logic [IDX_W-1:0]    slot_wide;
  logic [RING_AW-1:0]  slot;
  logic [RING_AW-1:0]  newest_nx;
  logic [RING_AW-1:0]  ofs_raddr;
  logic [OFS_W-1:0]    ofs_rdata;
  logic [OFS_W-1:0]    ofs_rd;
  logic [CALC_W-1:0]   end_sum;
  logic [OFS_W-1:0]    end_ofs;
  logic [STORE_AW-1:0] dest_wrap;
  logic                len_nz;
  logic [CALC_W-1:0]   span;
  logic [CALC_W-1:0]   maxl;
  logic [CALC_W-1:0]   clip;
  logic [STORE_AW-1:0] byte_raddr;
  logic                byte_we;
  logic [STORE_AW-1:0] byte_waddr;
  logic [7:0]          byte_rdata;

  assign count_wide = (newest_q >= oldest_q) ?
                      {1'b0, newest_q} - {1'b0, oldest_q} :
                      {1'b0, newest_q} + RING_N_C - {1'b0, oldest_q};
  assign count      = RING_AW'(count_wide);

  assign which_x   = IDX_W'(item_q.which) + 1'b1;
  assign newest_x  = IDX_W'(newest_q);
  assign slot_wide = (newest_x >= which_x) ? newest_x - which_x :
                     newest_x + RING_IDX_C - which_x;
  assign slot      = RING_AW'(slot_wide);
  assign newest_nx = ring_inc(newest_q);

  always_comb begin
    case (cmd_i.ofs_sel)
      OFS_NEWEST: ofs_raddr = newest_q;
      OFS_OLDEST: ofs_raddr = oldest_q;
      OFS_SLOT:   ofs_raddr = slot;
      OFS_NEXT:   ofs_raddr = ring_inc(slot);
      default:    ofs_raddr = newest_q;
    endcase
  end

  assign ofs_rd    = rd_vld_q ? ofs_rdata : '0;
  assign end_sum   = CALC_W'(dest_q) + CALC_W'(item_q.line_length);
  assign end_ofs   = (end_sum >= OFS_MOD_C) ? OFS_W'(end_sum - OFS_MOD_C) : OFS_W'(end_sum);
  assign dest_wrap = store_wrap(CALC_W'(dest_q));
  assign len_nz    = (item_q.line_length != '0);

  assign span = ofs_diff(CALC_W'(ofs_rd), CALC_W'(slot_ofs_q));
  assign maxl = CALC_W'(item_q.max_length);
  assign clip = (maxl == '0) ? '0 : ((span >= maxl) ? maxl - 1'b1 : span);

  assign byte_raddr = store_wrap(CALC_W'(store_wrap(CALC_W'(slot_ofs_q)))
                                 + CALC_W'(item_q.offset));
  assign byte_we    = cmd_i.store_byte || (cmd_i.commit && len_nz);
  assign byte_waddr = cmd_i.commit ? dest_wrap : wp_q;

  always_comb begin
    status_o.act_append    = (item_q.action == ACT_APPEND);
    status_o.act_fetch     = (item_q.action == ACT_FETCH);
    status_o.act_discard   = (item_q.action == ACT_DISCARD);
    status_o.first         = item_q.first;
    status_o.len_ok        = (CALC_W'(item_q.line_length) <= HALF_C);
    status_o.ring_full     = (count == RING_LAST);
    status_o.pending       = (rem_q != '0);
    status_o.which_ok      = (IDX_W'(item_q.which) < IDX_W'(count));
    status_o.have_record   = (count != '0);
    status_o.fits          = ((ofs_diff(CALC_W'(dest_q), CALC_W'(ofs_rd))
                               + CALC_W'(item_q.line_length)) <= STORE_C);
    status_o.byte_in_range = (CALC_W'(item_q.offset) < CALC_W'(size_q));
  end

  always_comb begin
    oldest_d = oldest_q;
    newest_d = newest_q;
    wp_d     = wp_q;
    rem_d    = rem_q;
    valid_d  = valid_q;
    if (cmd_i.clear_pending) begin
      rem_d = '0;
    end
    if (cmd_i.oldest_inc) begin
      oldest_d = ring_inc(oldest_q);
    end
    if (cmd_i.discard) begin
      newest_d = ring_dec(newest_q);
    end
    if (cmd_i.store_byte) begin
      wp_d  = store_inc(wp_q);
      rem_d = rem_q - 1'b1;
    end
    if (cmd_i.commit) begin
      newest_d           = newest_nx;
      valid_d[newest_nx] = 1'b1;
      if (len_nz) begin
        wp_d  = store_inc(dest_wrap);
        rem_d = OFS_W'(item_q.line_length) - 1'b1;
      end else begin
        wp_d  = dest_wrap;
        rem_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      newest_q <= '0;
      wp_q     <= '0;
      rem_q    <= '0;
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      wp_q     <= wp_d;
      rem_q    <= rem_d;
      valid_q  <= valid_d;
      done_q   <= cmd_i.emit;
      if (cmd_i.ofs_re) begin
        rd_vld_q <= valid_q[ofs_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      item_q  <= item_i;
      acc_q   <= 1'b0;
      fbyte_q <= '0;
      size_q  <= '0;
    end else begin
      if (cmd_i.set_acc) begin
        acc_q <= 1'b1;
      end
      if (cmd_i.cap_size) begin
        size_q <= LEN_W'(clip);
      end
      if (cmd_i.cap_byte) begin
        fbyte_q <= byte_rdata;
      end
    end
    if (cmd_i.cap_dest) begin
      dest_q <= ofs_rd;
    end
    if (cmd_i.cap_slot_ofs) begin
      slot_ofs_q <= ofs_rd;
    end
    if (cmd_i.emit) begin
      result_q.accepted       <= acc_q;
      result_q.entry_count    <= 7'(count);
      result_q.fetched_byte   <= fbyte_q;
      result_q.fetched_length <= size_q[12:0];
    end
  end

  lhr_ram #(
    .WIDTH(OFS_W),
    .DEPTH(RING_ENTRIES)
  ) u_ofs_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit),
    .waddr_i(newest_nx),
    .wdata_i(end_ofs),
    .re_i   (cmd_i.ofs_re),
    .raddr_i(ofs_raddr),
    .rdata_o(ofs_rdata)
  );

  lhr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_byte_ram (
    .clk_i  (clk_i),
    .we_i   (byte_we),
    .waddr_i(byte_waddr),
    .wdata_i(item_q.data_byte),
    .re_i   (cmd_i.byte_re),
    .raddr_i(byte_raddr),
    .rdata_o(byte_rdata)
  );

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

/* hw/rtl/lhr_ctrl.sv */
// ----------------------------------------------------------------------------
// Line history ring controller
// Sequences each beat through the offset ring and byte store accesses.
// ----------------------------------------------------------------------------
module lhr_ctrl
  import lhr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  lhr_status_t status_i,
  output logic        busy_o,
  output lhr_cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_DISPATCH  = 10'b0000000010,
    S_APP_DEST  = 10'b0000000100,
    S_EVICT_RD  = 10'b0000001000,
    S_EVICT_CHK = 10'b0000010000,
    S_FET_SLOT  = 10'b0000100000,
    S_FET_NEXT  = 10'b0001000000,
    S_FET_BRD   = 10'b0010000000,
    S_FET_BYTE  = 10'b0100000000,
    S_RESP      = 10'b1000000000
  } lhr_state_e;

  lhr_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch_item = 1'b1;
          state_d          = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_RESP;
        if (status_i.act_append) begin
          if (status_i.first) begin
            cmd_o.clear_pending = 1'b1;
            if (status_i.len_ok) begin
              cmd_o.oldest_inc = status_i.ring_full;
              cmd_o.ofs_re     = 1'b1;
              cmd_o.ofs_sel    = OFS_NEWEST;
              state_d          = S_APP_DEST;
            end
          end else if (status_i.pending) begin
            cmd_o.store_byte = 1'b1;
            cmd_o.set_acc    = 1'b1;
          end
        end else if (status_i.act_fetch) begin
          if (status_i.which_ok) begin
            cmd_o.set_acc = 1'b1;
            cmd_o.ofs_re  = 1'b1;
            cmd_o.ofs_sel = OFS_SLOT;
            state_d       = S_FET_SLOT;
          end
        end else if (status_i.act_discard) begin
          cmd_o.clear_pending = 1'b1;
          if (status_i.have_record) begin
            cmd_o.discard = 1'b1;
            cmd_o.set_acc = 1'b1;
          end
        end
      end
      S_APP_DEST: begin
        cmd_o.cap_dest = 1'b1;
        state_d        = S_EVICT_RD;
      end
      S_EVICT_RD: begin
        cmd_o.ofs_re  = 1'b1;
        cmd_o.ofs_sel = OFS_OLDEST;
        state_d       = S_EVICT_CHK;
      end
      S_EVICT_CHK: begin
        if (status_i.fits) begin
          cmd_o.commit  = 1'b1;
          cmd_o.set_acc = 1'b1;
          state_d       = S_RESP;
        end else begin
          cmd_o.oldest_inc = 1'b1;
          state_d          = S_EVICT_RD;
        end
      end
      S_FET_SLOT: begin
        cmd_o.cap_slot_ofs = 1'b1;
        cmd_o.ofs_re       = 1'b1;
        cmd_o.ofs_sel      = OFS_NEXT;
        state_d            = S_FET_NEXT;
      end
      S_FET_NEXT: begin
        cmd_o.cap_size = 1'b1;
        state_d        = S_FET_BRD;
      end
      S_FET_BRD: begin
        if (status_i.byte_in_range) begin
          cmd_o.byte_re = 1'b1;
          state_d       = S_FET_BYTE;
        end else begin
          state_d = S_RESP;
        end
      end
      S_FET_BYTE: begin
        cmd_o.cap_byte = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* hw/rtl/line_history_ring.sv */
// ----------------------------------------------------------------------------
// Line history ring
// Variable-length record history held in a circular byte store.
//
// Channel   Direction  Handshake            Payload
// command   in         start & !busy        item_i   (item_t)
// result    out        done_o, one cycle    result_o (result_t)
//
// A continuation byte, a discard, a rejected record or an unknown action
// goes from dispatch straight to the response state. A fetch reads the slot
// and next offsets, then reads the byte only when it lies inside the clipped
// length. A first beat reads the newest offset, then evicts old records in a
// walk over the offset ring, which has one read port with registered data.
// Reset empties the ring at once through per-slot valid bits. The receiver
// cannot stall: done_o marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
module line_history_ring
  import lhr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  item_t   item_i,
  output logic    busy,
  output logic    done_o,
  output result_t result_o
);

  lhr_cmd_t    cmd;
  lhr_status_t status;

  lhr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .status_i(status),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  lhr_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .cmd_i   (cmd),
    .status_o(status),
    .done_o  (done_o),
    .result_o(result_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Accepted beat did not make the block busy.");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe held for more than one cycle.");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("Block went idle without giving a result.");

  a_reject_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.accepted) |->
      (result_o.fetched_length == '0 && result_o.fetched_byte == '0))
    else $error("Rejected beat returned fetch data.");
`endif

endmodule
